>>> design/llwp_pkg.sv
// Shared types, character codes and helper functions for the labelled-line
// word-prefix tokenizer. No dependencies.
package llwp_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 16;
   localparam int OUT_COUNT_WIDTH = 16;
   localparam int PREFIX_WIDTH = 4;
   localparam int PAD_WIDTH = 3;

   localparam logic [PREFIX_WIDTH-1:0] PREFIX_RESET = 4'd4;
   localparam logic [PREFIX_WIDTH-1:0] PREFIX_MIN = 4'd1;
   localparam logic [PREFIX_WIDTH-1:0] PREFIX_MAX = 4'd8;

   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_ZERO = 8'd48;
   localparam logic [7:0] CHAR_ONE = 8'd49;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'd95;
   localparam logic [7:0] CHAR_LOWER_A = 8'd97;
   localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
   localparam logic [7:0] CHAR_UPPER_A = 8'd65;
   localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
   localparam logic [7:0] CHAR_HAM = 8'd104;
   localparam logic [7:0] CHAR_SPAM = 8'd115;
   localparam logic [7:0] CASE_OFFSET = 8'd32;

   // One input transaction's worth of results: an optional head result, an
   // optional letter, a run of underscores and an optional newline.
   typedef struct packed {
      logic                       head_en;
      logic [7:0]                 head_char;
      logic                       head_valid;
      logic                       head_bad;
      logic                       letter_en;
      logic [7:0]                 letter_char;
      logic [PAD_WIDTH-1:0]       pad_cnt;
      logic                       nl_en;
      logic [OUT_COUNT_WIDTH-1:0] ham;
      logic [OUT_COUNT_WIDTH-1:0] spam;
   } burst_type;

   function automatic logic is_letter(input logic [7:0] ch);
      return ((ch >= CHAR_LOWER_A) && (ch <= CHAR_LOWER_Z)) ||
             ((ch >= CHAR_UPPER_A) && (ch <= CHAR_UPPER_Z));
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] ch);
      return (ch < CHAR_LOWER_A) ? ch + CASE_OFFSET : ch;
   endfunction

   function automatic logic [PREFIX_WIDTH-1:0] eff_prefix(input logic [PREFIX_WIDTH-1:0] p);
      logic [PREFIX_WIDTH-1:0] r;
      if (p < PREFIX_MIN) begin
         r = PREFIX_MIN;
      end else if (p > PREFIX_MAX) begin
         r = PREFIX_MAX;
      end else begin
         r = p;
      end
      return r;
   endfunction

endpackage

>>> design/llwp_parser.sv
// Line and word parser: holds the parse mode, letter count and line counters
// and turns each accepted character into a result burst. Uses llwp_pkg.
module llwp_parser import llwp_pkg::*; #(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              in_char,
   input  logic [PREFIX_WIDTH-1:0] prefix_length,
   output burst_type               burst,
   output logic                    burst_any
);

   typedef enum logic [1:0] {
      LINE_START,
      LABEL,
      GAP,
      WORD
   } mode_type;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   mode_type                mode_ff, mode_in;
   logic [PREFIX_WIDTH-1:0] letters_ff, letters_in;
   logic [COUNT_WIDTH-1:0]  ham_ff, ham_in;
   logic [COUNT_WIDTH-1:0]  spam_ff, spam_in;

   logic                    alpha;
   logic                    nl;
   logic [PREFIX_WIDTH-1:0] prefix;
   logic [PREFIX_WIDTH-1:0] pad_full;
   logic [COUNT_WIDTH+OUT_COUNT_WIDTH-1:0] ham_wide;
   logic [COUNT_WIDTH+OUT_COUNT_WIDTH-1:0] spam_wide;

   assign alpha = is_letter(in_char);
   assign nl = (in_char == CHAR_NEWLINE);
   assign prefix = eff_prefix(prefix_length);
   assign pad_full = (letters_ff < prefix) ? prefix - letters_ff : '0;

   always_comb begin
      mode_in = mode_ff;
      letters_in = letters_ff;
      ham_in = ham_ff;
      spam_in = spam_ff;
      burst = '0;
      unique case (mode_ff)
         LINE_START: begin
            if (in_char == CHAR_HAM) begin
               if (ham_ff != COUNT_MAX) begin
                  ham_in = ham_ff + 1'b1;
               end
               burst.head_en = 1'b1;
               burst.head_char = CHAR_ZERO;
               burst.head_valid = 1'b1;
               mode_in = LABEL;
            end else if (in_char == CHAR_SPAM) begin
               if (spam_ff != COUNT_MAX) begin
                  spam_in = spam_ff + 1'b1;
               end
               burst.head_en = 1'b1;
               burst.head_char = CHAR_ONE;
               burst.head_valid = 1'b1;
               mode_in = LABEL;
            end else begin
               burst.head_en = 1'b1;
               burst.head_bad = 1'b1;
               if (alpha) begin
                  mode_in = LABEL;
               end else if (nl) begin
                  burst.nl_en = 1'b1;
                  mode_in = LINE_START;
               end else begin
                  mode_in = GAP;
               end
            end
         end
         LABEL: begin
            if (nl) begin
               burst.nl_en = 1'b1;
               mode_in = LINE_START;
            end else if (!alpha) begin
               mode_in = GAP;
            end
         end
         GAP: begin
            if (nl) begin
               burst.nl_en = 1'b1;
               mode_in = LINE_START;
            end else if (alpha) begin
               burst.head_en = 1'b1;
               burst.head_char = CHAR_SPACE;
               burst.head_valid = 1'b1;
               burst.letter_en = 1'b1;
               burst.letter_char = to_lower(in_char);
               letters_in = PREFIX_MIN;
               mode_in = WORD;
            end
         end
         WORD: begin
            if (alpha) begin
               if (letters_ff < prefix) begin
                  burst.head_en = 1'b1;
                  burst.head_char = to_lower(in_char);
                  burst.head_valid = 1'b1;
                  letters_in = letters_ff + 1'b1;
               end
            end else begin
               burst.pad_cnt = pad_full[PAD_WIDTH-1:0];
               if (nl) begin
                  burst.nl_en = 1'b1;
                  mode_in = LINE_START;
               end else begin
                  mode_in = GAP;
               end
            end
         end
         default: begin
            mode_in = LINE_START;
         end
      endcase
      if (mode_in != WORD) begin
         letters_in = '0;
      end
      ham_wide = {{OUT_COUNT_WIDTH{1'b0}}, ham_in};
      spam_wide = {{OUT_COUNT_WIDTH{1'b0}}, spam_in};
      burst.ham = ham_wide[OUT_COUNT_WIDTH-1:0];
      burst.spam = spam_wide[OUT_COUNT_WIDTH-1:0];
   end

   assign burst_any = burst.head_en | burst.letter_en | (burst.pad_cnt != '0) | burst.nl_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= LINE_START;
         letters_ff <= '0;
         ham_ff <= '0;
         spam_ff <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         letters_ff <= letters_in;
         ham_ff <= ham_in;
         spam_ff <= spam_in;
      end
   end

   a_letters_in_word: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != WORD) |-> (letters_ff == '0))
      else $error("letter count nonzero outside a word");

   a_letters_bounded: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == WORD) |-> ((letters_ff >= PREFIX_MIN) && (letters_ff <= PREFIX_MAX)))
      else $error("letter count out of range inside a word");

endmodule

>>> design/llwp_emitter.sv
// Burst serializer and result register: plays out one burst, one result per
// cycle while rsp_ready lets it, into the output register. Uses llwp_pkg.
module llwp_emitter import llwp_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  burst_type                  burst,
   output logic                       load_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [7:0]                 rsp_out_char,
   output logic                       rsp_char_valid,
   output logic                       rsp_bad_label,
   output logic [OUT_COUNT_WIDTH-1:0] rsp_ham_count,
   output logic [OUT_COUNT_WIDTH-1:0] rsp_spam_count,
   output logic                       rsp_last
);

   burst_type                  seq_ff, seq_in, seq_left;
   logic                       busy;
   logic                       emit;
   logic                       done;
   logic [7:0]                 char_sel;
   logic                       valid_sel;
   logic                       bad_sel;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [7:0]                 char_ff;
   logic                       char_valid_ff;
   logic                       bad_ff;
   logic [OUT_COUNT_WIDTH-1:0] ham_ff;
   logic [OUT_COUNT_WIDTH-1:0] spam_ff;
   logic                       last_ff;

   assign busy = seq_ff.head_en | seq_ff.letter_en | (seq_ff.pad_cnt != '0) | seq_ff.nl_en;
   assign emit = busy && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      seq_left = seq_ff;
      char_sel = CHAR_NEWLINE;
      valid_sel = 1'b1;
      bad_sel = 1'b0;
      priority if (seq_ff.head_en) begin
         char_sel = seq_ff.head_char;
         valid_sel = seq_ff.head_valid;
         bad_sel = seq_ff.head_bad;
         seq_left.head_en = 1'b0;
      end else if (seq_ff.letter_en) begin
         char_sel = seq_ff.letter_char;
         seq_left.letter_en = 1'b0;
      end else if (seq_ff.pad_cnt != '0) begin
         char_sel = CHAR_UNDERSCORE;
         seq_left.pad_cnt = seq_ff.pad_cnt - 1'b1;
      end else begin
         seq_left.nl_en = 1'b0;
      end
   end

   assign done = !(seq_left.head_en | seq_left.letter_en | (seq_left.pad_cnt != '0) |
                   seq_left.nl_en);
   assign load_ready = !busy || (emit && done);

   always_comb begin
      seq_in = seq_ff;
      if (load) begin
         seq_in = burst;
      end else if (emit) begin
         seq_in = seq_left;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         char_ff <= valid_sel ? char_sel : 8'd0;
         char_valid_ff <= valid_sel;
         bad_ff <= bad_sel;
         ham_ff <= seq_ff.ham;
         spam_ff <= seq_ff.spam;
         last_ff <= done;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_char = char_ff;
   assign rsp_char_valid = char_valid_ff;
   assign rsp_bad_label = bad_ff;
   assign rsp_ham_count = ham_ff;
   assign rsp_spam_count = spam_ff;
   assign rsp_last = last_ff;

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> load_ready)
      else $error("burst loaded over one still in progress");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (emit && done && !load) |=> !busy)
      else $error("burst still busy after its last result");

endmodule

>>> design/labelled_line_word_prefix_tokenizer.sv
// Top level of the labelled-line word-prefix tokenizer: parser, burst
// serializer and the prefix length register. Uses llwp_pkg, llwp_parser and
// llwp_emitter.
// The results of an accepted character are loaded into the burst register and
// then registered into the output register. Characters that cause one result or
// none flow at one per cycle while the output is not stalled; a character that
// causes more results holds the serializer until its last result is emitted.
// Reset is synchronous: line start, zero counts and prefix length 4.
module labelled_line_word_prefix_tokenizer import llwp_pkg::*; #(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [7:0]                 req_in_char,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [7:0]                 rsp_out_char,
   output logic                       rsp_char_valid,
   output logic                       rsp_bad_label,
   output logic [OUT_COUNT_WIDTH-1:0] rsp_ham_count,
   output logic [OUT_COUNT_WIDTH-1:0] rsp_spam_count,
   output logic                       rsp_last,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [PREFIX_WIDTH-1:0]    csr_prefix_length
);

   logic [PREFIX_WIDTH-1:0] prefix_ff;
   logic                    accept;
   logic                    load_ready;
   burst_type               burst;
   logic                    burst_any;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= PREFIX_RESET;
      end else if (csr_valid && csr_ready) begin
         prefix_ff <= csr_prefix_length;
      end
   end

   assign req_ready = load_ready;
   assign accept = req_valid && req_ready;

   llwp_parser #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_parser (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .in_char(req_in_char),
      .prefix_length(prefix_ff),
      .burst(burst),
      .burst_any(burst_any)
   );

   llwp_emitter u_emitter (
      .clock(clock),
      .reset(reset),
      .load(accept && burst_any),
      .burst(burst),
      .load_ready(load_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_char(rsp_out_char),
      .rsp_char_valid(rsp_char_valid),
      .rsp_bad_label(rsp_bad_label),
      .rsp_ham_count(rsp_ham_count),
      .rsp_spam_count(rsp_spam_count),
      .rsp_last(rsp_last)
   );

endmodule

>>> test/testbench.sv
// Self-checking testbench for labelled_line_word_prefix_tokenizer: a token predictor
// feeds a scoreboard that checks every emitted character, with random gaps on both channels.
// Depends on llwp_pkg and the tokenizer RTL only.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import llwp_pkg::*;

   localparam int CLOCK_PERIOD = 8;
   localparam int RESET_CYCLES = 7;
   localparam int STALL_LIMIT = 2000;
   localparam int PHASE_ITEMS = 32;
   localparam int PRINT_CAP = 100;

   typedef enum logic [1:0] {
      LINE_START,
      LABEL_WORD,
      WORD_GAP,
      BODY_WORD
   } parse_mode_type;

   typedef struct packed {
      logic [7:0]                 ch;
      logic                       char_ok;
      logic                       bad;
      logic [OUT_COUNT_WIDTH-1:0] ham;
      logic [OUT_COUNT_WIDTH-1:0] spam;
      logic                       last;
   } token_type;

   class token_checker;
      parse_mode_type                 mode;
      int unsigned                    letters;
      logic [COUNT_WIDTH_DEFAULT-1:0] ham_lines;
      logic [COUNT_WIDTH_DEFAULT-1:0] spam_lines;
      logic [PREFIX_WIDTH-1:0]        prefix;
      token_type                      expected_tokens[$];
      int                             mismatches;

      function new();
         mode = LINE_START;
         letters = 0;
         ham_lines = '0;
         spam_lines = '0;
         prefix = PREFIX_RESET;
         mismatches = 0;
      endfunction

      static function logic is_alpha(logic [7:0] c);
         return ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
                ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));
      endfunction

      function int outstanding();
         return expected_tokens.size();
      endfunction

      function void set_prefix(logic [PREFIX_WIDTH-1:0] v);
         prefix = v;
      endfunction

      function void emit(logic [7:0] c, logic char_ok, logic bad);
         token_type t;
         t.ch = c;
         t.char_ok = char_ok;
         t.bad = bad;
         t.ham = OUT_COUNT_WIDTH'(ham_lines);
         t.spam = OUT_COUNT_WIDTH'(spam_lines);
         t.last = 1'b0;
         expected_tokens.push_back(t);
      endfunction

      function void predict_char(logic [7:0] c);
         logic        alpha;
         logic        nl;
         logic [7:0]  low;
         int unsigned keep;
         int          first;
         alpha = is_alpha(c);
         nl = (c == CHAR_NEWLINE);
         low = (c < CHAR_LOWER_A) ? c + CASE_OFFSET : c;
         keep = (prefix < PREFIX_MIN) ? PREFIX_MIN : (prefix > PREFIX_MAX) ? PREFIX_MAX : prefix;
         first = expected_tokens.size();
         case (mode)
            LINE_START: begin
               if (c == CHAR_HAM) begin
                  if (ham_lines != '1) ham_lines++;
                  emit(CHAR_ZERO, 1'b1, 1'b0);
                  mode = LABEL_WORD;
               end else if (c == CHAR_SPAM) begin
                  if (spam_lines != '1) spam_lines++;
                  emit(CHAR_ONE, 1'b1, 1'b0);
                  mode = LABEL_WORD;
               end else begin
                  emit(8'd0, 1'b0, 1'b1);
                  if (alpha) begin
                     mode = LABEL_WORD;
                  end else if (nl) begin
                     emit(CHAR_NEWLINE, 1'b1, 1'b0);
                     mode = LINE_START;
                  end else begin
                     mode = WORD_GAP;
                  end
               end
            end
            LABEL_WORD: begin
               if (nl) begin
                  emit(CHAR_NEWLINE, 1'b1, 1'b0);
                  mode = LINE_START;
               end else if (!alpha) begin
                  mode = WORD_GAP;
               end
            end
            WORD_GAP: begin
               if (nl) begin
                  emit(CHAR_NEWLINE, 1'b1, 1'b0);
                  mode = LINE_START;
               end else if (alpha) begin
                  emit(CHAR_SPACE, 1'b1, 1'b0);
                  emit(low, 1'b1, 1'b0);
                  letters = 1;
                  mode = BODY_WORD;
               end
            end
            default: begin
               if (alpha) begin
                  if (letters < keep) begin
                     emit(low, 1'b1, 1'b0);
                     letters++;
                  end
               end else begin
                  while (letters < keep) begin
                     emit(CHAR_UNDERSCORE, 1'b1, 1'b0);
                     letters++;
                  end
                  if (nl) begin
                     emit(CHAR_NEWLINE, 1'b1, 1'b0);
                     mode = LINE_START;
                  end else begin
                     mode = WORD_GAP;
                  end
               end
            end
         endcase
         if (mode != BODY_WORD) letters = 0;
         if (expected_tokens.size() > first) expected_tokens[$].last = 1'b1;
      endfunction

      task report(string what);
         if (mismatches < PRINT_CAP) $display("MISMATCH at %0t: %s", $time, what);
         mismatches++;
      endtask

      task compare_field(string name, logic [15:0] got, logic [15:0] want);
         if (got !== want) report($sformatf("%s got %0h, expected %0h", name, got, want));
      endtask

      task check_token(token_type got);
         token_type want;
         if (expected_tokens.size() == 0) begin
            report($sformatf("result with no expectation, out_char %0h", got.ch));
         end else begin
            want = expected_tokens.pop_front();
            compare_field("out_char", got.ch, want.ch);
            compare_field("char_valid", got.char_ok, want.char_ok);
            compare_field("bad_label", got.bad, want.bad);
            compare_field("ham_count", got.ham, want.ham);
            compare_field("spam_count", got.spam, want.spam);
            compare_field("last", got.last, want.last);
         end
      endtask
   endclass

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [7:0]                 req_in_char;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [7:0]                 rsp_out_char;
   logic                       rsp_char_valid;
   logic                       rsp_bad_label;
   logic [OUT_COUNT_WIDTH-1:0] rsp_ham_count;
   logic [OUT_COUNT_WIDTH-1:0] rsp_spam_count;
   logic                       rsp_last;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [PREFIX_WIDTH-1:0]    csr_prefix_length;

   token_checker sb;
   logic [7:0]   text_q[$];
   int           idle_odds = 3;
   int           rsp_hold = 0;
   int unsigned  quiet_cycles = 0;

   labelled_line_word_prefix_tokenizer uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_in_char(req_in_char),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_char(rsp_out_char),
      .rsp_char_valid(rsp_char_valid),
      .rsp_bad_label(rsp_bad_label),
      .rsp_ham_count(rsp_ham_count),
      .rsp_spam_count(rsp_spam_count),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_prefix_length(csr_prefix_length)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin : monitor
      token_type seen;
      if (!reset) begin
         if (csr_valid && csr_ready) sb.set_prefix(csr_prefix_length);
         if (req_valid && req_ready) sb.predict_char(req_in_char);
         if (rsp_valid && rsp_ready) begin
            seen = '{rsp_out_char, rsp_char_valid, rsp_bad_label, rsp_ham_count,
                     rsp_spam_count, rsp_last};
            sb.check_token(seen);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("testbench failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_ready = 1'b0;
            rsp_hold--;
         end else begin
            rsp_ready = 1'b1;
            if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
               rsp_hold = $urandom_range(1, 4);
            end
         end
      end
   end

   task automatic send_char(logic [7:0] c);
      @(negedge clock);
      req_valid = 1'b1;
      req_in_char = c;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic feed(logic [7:0] c);
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         repeat ($urandom_range(1, 4)) begin
            @(negedge clock);
            req_valid = 1'b0;
         end
      end
      send_char(c);
   endtask

   task automatic feed_text();
      while (text_q.size() != 0) feed(text_q.pop_front());
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
   endtask

   // Characters that yield no token may still be in flight after the last token.
   task automatic load_prefix(logic [PREFIX_WIDTH-1:0] v);
      drain();
      repeat (4) @(negedge clock);
      csr_valid = 1'b1;
      csr_prefix_length = v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   function automatic logic [7:0] random_letter();
      return (($urandom_range(0, 1) != 0) ? CHAR_UPPER_A : CHAR_LOWER_A) +
             8'($urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] random_separator();
      logic [7:0] c;
      if ($urandom_range(0, 3) != 0) return CHAR_SPACE;
      do c = 8'($urandom_range(0, 255));
      while (token_checker::is_alpha(c) || c == CHAR_NEWLINE);
      return c;
   endfunction

   task automatic append_line();
      int len;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
         return;
      end
      case ($urandom_range(0, 9))
         0: text_q.push_back(8'($urandom_range(0, 255)));
         1, 2, 3, 4: text_q.push_back(CHAR_HAM);
         default: text_q.push_back(CHAR_SPAM);
      endcase
      repeat ($urandom_range(0, 3)) text_q.push_back(random_letter());
      repeat ($urandom_range(0, 4)) begin
         repeat ($urandom_range(1, 2)) text_q.push_back(random_separator());
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
         repeat (len) text_q.push_back(random_letter());
      end
      if ($urandom_range(0, 3) == 0) text_q.push_back(random_separator());
      text_q.push_back(CHAR_NEWLINE);
   endtask

   initial begin
      logic [PREFIX_WIDTH-1:0] phase_prefix[6];
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_char = 8'd0;
      csr_valid = 1'b0;
      csr_prefix_length = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      push_text("h Az\ns");
      text_q.push_back(8'h00);
      push_text("Za");
      text_q.push_back(8'hFF);
      push_text("\n\n#q\nQx Abcdef\n");
      feed_text();

      phase_prefix = '{4'd8, 4'd1, 4'd0, 4'd15, 4'($urandom_range(2, 7)),
                       4'($urandom_range(0, 15))};
      for (int p = 0; p < 6; p++) begin
         load_prefix(phase_prefix[p]);
         idle_odds = (p % 2 == 0) ? 3 : 0;
         while (text_q.size() < PHASE_ITEMS) append_line();
         while (text_q.size() > PHASE_ITEMS) void'(text_q.pop_back());
         while (text_q.size() != 0) begin
            if (p == 2 && text_q.size() == PHASE_ITEMS / 2) drain();
            feed(text_q.pop_front());
         end
      end

      // A few closing lines run back to back with no idling on either side.
      idle_odds = 0;
      load_prefix(4'($urandom_range(1, 8)));
      repeat (3) append_line();
      feed_text();

      drain();
      repeat (10) @(negedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end
endmodule
